>>> hdl/rgb_led_fade_command_controller_defines.svh
// Assertion macros shared by the LED fade controller modules.
`ifndef RGB_LED_FADE_COMMAND_CONTROLLER_DEFINES_SVH
`define RGB_LED_FADE_COMMAND_CONTROLLER_DEFINES_SVH

// Same-cycle implication, checked on clk and held off during reset.
`define RLFC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk and held off during reset.
`define RLFC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/rlfc_pkg.sv
// Types, constants and helper functions for the LED fade controller.
`default_nettype none
package rlfc_pkg;

	localparam int DUTY_W = 8;
	localparam int POS_W  = 3;

	typedef logic [DUTY_W-1:0] duty_t;
	typedef logic [POS_W-1:0]  pos_t;

	// Request kinds carried on the input channel.
	typedef enum logic [1:0] {
		KIND_BYTE = 2'd0,
		KIND_SEC  = 2'd1,
		KIND_FADE = 2'd2,
		KIND_NONE = 2'd3
	} kind_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_TIMEOUT = 2'd0,
		REG_START   = 2'd1,
		REG_END     = 2'd2,
		REG_UNUSED  = 2'd3
	} cfg_reg_t;

	// One-hot event strobes from the input stage to the state units.
	typedef struct packed {
		logic take_byte;
		logic sec_tick;
		logic fade_tick;
	} item_ctl_t;

	localparam duty_t TIMEOUT_RST   = 8'd10;
	localparam duty_t START_RST     = 8'd33;
	localparam duty_t END_RST       = 8'd10;
	localparam duty_t COUNTDOWN_RST = 8'd10;
	localparam duty_t TARGET_FULL   = 8'hff;
	localparam duty_t TARGET_DARK   = 8'h00;
	localparam duty_t LEVEL_RST     = 8'h00;

	// Move a duty one step toward its target.
	function automatic duty_t step_toward(input duty_t level, input duty_t target);
		duty_t r;
		r = level;
		if (level < target) begin
			r = level + 8'd1;
		end else if (level > target) begin
			r = level - 8'd1;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> hdl/rlfc_frame.sv
// Command framing, target colors and inactivity countdown.
`default_nettype none
`include "rgb_led_fade_command_controller_defines.svh"
module rlfc_frame import rlfc_pkg::*; #(
	parameter int FRAME_BYTES = 6
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire item_ctl_t ctl,
	input  wire duty_t     rx_byte,
	input  wire duty_t     timeout_reload,
	input  wire duty_t     start_byte,
	input  wire duty_t     end_byte,
	output duty_t          target_red,
	output duty_t          target_green,
	output duty_t          target_blue,
	output duty_t          countdown_next
);

	localparam pos_t FRAME_LEN = POS_W'(FRAME_BYTES);

	duty_t tr_q, tg_q, tb_q, cd_q;
	duty_t tr_d, tg_d, tb_d, cd_d;
	pos_t  pos_q, pos_d, pos_inc;

	// Next state for a received byte or a one-second tick.
	always_comb begin
		tr_d    = tr_q;
		tg_d    = tg_q;
		tb_d    = tb_q;
		cd_d    = cd_q;
		pos_d   = pos_q;
		pos_inc = pos_q + 3'd1;
		if (ctl.take_byte && !(pos_q == '0 && rx_byte != start_byte)) begin
			cd_d = timeout_reload;
			if (rx_byte == end_byte) begin
				tg_d = TARGET_FULL;
				if (pos_inc == FRAME_LEN) begin
					tb_d = TARGET_FULL;
				end
				pos_d = '0;
			end else if (pos_inc >= FRAME_LEN) begin
				pos_d = '0;
				tr_d  = TARGET_FULL;
			end else begin
				pos_d = pos_inc;
			end
		end
		if (ctl.sec_tick) begin
			if (cd_q != '0) begin
				cd_d = cd_q - 8'd1;
			end else begin
				tr_d = TARGET_DARK;
				tg_d = TARGET_DARK;
				tb_d = TARGET_DARK;
			end
		end
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tr_q  <= TARGET_FULL;
			tg_q  <= TARGET_FULL;
			tb_q  <= TARGET_FULL;
			cd_q  <= COUNTDOWN_RST;
			pos_q <= '0;
		end else begin
			tr_q  <= tr_d;
			tg_q  <= tg_d;
			tb_q  <= tb_d;
			cd_q  <= cd_d;
			pos_q <= pos_d;
		end
	end

	assign target_red     = tr_q;
	assign target_green   = tg_q;
	assign target_blue    = tb_q;
	assign countdown_next = cd_d;

	// The frame position never reaches the frame length.
	`RLFC_ASSERT_NOW(a_pos_range, 1'b1, pos_q < FRAME_LEN, "frame position out of range")
	// The countdown only changes on a byte or a tick.
	`RLFC_ASSERT_NEXT(a_cd_hold, !ctl.take_byte && !ctl.sec_tick, $stable(cd_q), "countdown moved without request")

endmodule
`default_nettype wire

>>> hdl/rlfc_fade.sv
// Duty levels that fade one step per fade tick toward the targets.
`default_nettype none
`include "rgb_led_fade_command_controller_defines.svh"
module rlfc_fade import rlfc_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire item_ctl_t ctl,
	input  wire duty_t     target_red,
	input  wire duty_t     target_green,
	input  wire duty_t     target_blue,
	output duty_t          level_red,
	output duty_t          level_green,
	output duty_t          level_blue
);

	duty_t lr_q, lg_q, lb_q;

	// Levels after this request.
	always_comb begin
		level_red   = lr_q;
		level_green = lg_q;
		level_blue  = lb_q;
		if (ctl.fade_tick) begin
			level_red   = step_toward(lr_q, target_red);
			level_green = step_toward(lg_q, target_green);
			level_blue  = step_toward(lb_q, target_blue);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q <= LEVEL_RST;
			lg_q <= LEVEL_RST;
			lb_q <= LEVEL_RST;
		end else begin
			lr_q <= level_red;
			lg_q <= level_green;
			lb_q <= level_blue;
		end
	end

	// Levels hold unless a fade tick arrives.
	`RLFC_ASSERT_NEXT(a_level_hold, !ctl.fade_tick, $stable(lr_q) && $stable(lg_q) && $stable(lb_q), "level moved without fade tick")

endmodule
`default_nettype wire

>>> hdl/rgb_led_fade_command_controller.sv
// Top level of the RGB LED fade controller with framed byte commands.
// A request passes the input register, then the result register; out_stall can delay it.
// Throughput: one request per cycle; stalls only with both registers full and out_stall.
// The input takes a new request while a finished result waits, if its register is empty.
// Reset: registers 10/33/10, targets full, fade levels dark, countdown 10, no frame open.
`default_nettype none
`include "rgb_led_fade_command_controller_defines.svh"
module rgb_led_fade_command_controller import rlfc_pkg::*; #(
	parameter int FRAME_BYTES = 6
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [1:0] kind,
	input  wire logic [7:0] rx_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      duty_red,
	output logic [7:0]      duty_green,
	output logic [7:0]      duty_blue,
	output logic [7:0]      countdown_left,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data
);

	duty_t     timeout_q, start_q, end_q;
	logic      valid_s1;
	kind_t     kind_s1;
	duty_t     rx_byte_s1;
	logic      out_valid_q;
	logic      adv;
	logic      fire;
	item_ctl_t ctl;
	duty_t     tr, tg, tb, cd_next, lr_next, lg_next, lb_next;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
			start_q   <= START_RST;
			end_q     <= END_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_TIMEOUT: timeout_q <= cfg_data;
				REG_START:   start_q   <= cfg_data;
				REG_END:     end_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// The input stage moves on when the result register is free or being taken.
	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !adv;
	assign fire     = valid_s1 && adv;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_s1    <= kind_t'(kind);
			rx_byte_s1 <= rx_byte;
		end
	end

	// Decode the request kind into event strobes.
	always_comb begin
		ctl = '0;
		case (kind_s1)
			KIND_BYTE: ctl.take_byte = fire;
			KIND_SEC:  ctl.sec_tick  = fire;
			KIND_FADE: ctl.fade_tick = fire;
			default: ;
		endcase
	end

	rlfc_frame #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_frame (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.rx_byte       (rx_byte_s1),
		.timeout_reload(timeout_q),
		.start_byte    (start_q),
		.end_byte      (end_q),
		.target_red    (tr),
		.target_green  (tg),
		.target_blue   (tb),
		.countdown_next(cd_next)
	);

	rlfc_fade u_fade (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.target_red  (tr),
		.target_green(tg),
		.target_blue (tb),
		.level_red   (lr_next),
		.level_green (lg_next),
		.level_blue  (lb_next)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			duty_red       <= lr_next;
			duty_green     <= lg_next;
			duty_blue      <= lb_next;
			countdown_left <= cd_next;
		end
	end

	assign out_valid = out_valid_q;

	// A processed request always lands in the result register.
	`RLFC_ASSERT_NEXT(a_fire_out, fire, out_valid_q, "processed request lost")
	// The input stalls only when both stages are full and the output is held.
	`RLFC_ASSERT_NOW(a_stall_cause, in_stall, valid_s1 && out_valid_q && out_stall, "spurious input stall")

endmodule
`default_nettype wire
